### design/heartbeat_liveness_table_defines.svh
// Assertion macros for the liveness table. The clock and reset names are fixed.
`ifndef HEARTBEAT_LIVENESS_TABLE_DEFINES_SVH
`define HEARTBEAT_LIVENESS_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hlt_pkg.sv
`default_nettype none

package hlt_pkg;

	localparam int KEY_W   = 64;
	localparam int TIME_W  = 32;
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int SLOT_W  = 5;
	localparam int COUNT_W = 6;
	localparam int CODE_W  = 2;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

	localparam logic [CODE_W-1:0] CMD_BEAT   = 2'd0;
	localparam logic [CODE_W-1:0] CMD_SWEEP  = 2'd1;
	localparam logic [CODE_W-1:0] CMD_LOOKUP = 2'd2;
	localparam logic [CODE_W-1:0] CMD_NONE   = 2'd3;

	localparam logic [CODE_W-1:0] ST_OK        = 2'd0;
	localparam logic [CODE_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [CODE_W-1:0] ST_FULL      = 2'd2;

	localparam logic [CODE_W-1:0] EV_NONE    = 2'd0;
	localparam logic [CODE_W-1:0] EV_ONLINE  = 2'd1;
	localparam logic [CODE_W-1:0] EV_OFFLINE = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] first_seen;
		logic [TIME_W-1:0] last_seen;
	} hlt_rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} hlt_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} hlt_ctl_t;

	typedef struct packed {
		logic cmd_nop;
		logic scan_end;
		logic out_free;
	} hlt_sts_t;

endpackage

`default_nettype wire

### design/hlt_if.sv
`default_nettype none

interface hlt_in_if;
	import hlt_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] cmd;
	logic [KEY_W-1:0]  device_key;
	logic [TIME_W-1:0] now_ms;
	logic [ADDR_W-1:0] peer_addr;
	logic              addr_present;
	logic [PORT_W-1:0] peer_port;

	modport source (
		output valid, cmd, device_key, now_ms, peer_addr, addr_present, peer_port,
		input  ready
	);
	modport sink (
		input  valid, cmd, device_key, now_ms, peer_addr, addr_present, peer_port,
		output ready
	);
endinterface

interface hlt_out_if;
	import hlt_pkg::*;

	logic               valid;
	logic               ready;
	logic [CODE_W-1:0]  status;
	logic [CODE_W-1:0]  event_kind;
	logic [KEY_W-1:0]   result_key;
	logic [SLOT_W-1:0]  slot_index;
	logic [ADDR_W-1:0]  stored_addr;
	logic [PORT_W-1:0]  stored_port;
	logic [TIME_W-1:0]  first_seen;
	logic [TIME_W-1:0]  last_seen;
	logic [COUNT_W-1:0] peer_count;
	logic               last;

	modport source (
		output valid, status, event_kind, result_key, slot_index, stored_addr,
			stored_port, first_seen, last_seen, peer_count, last,
		input  ready
	);
	modport sink (
		input  valid, status, event_kind, result_key, slot_index, stored_addr,
			stored_port, first_seen, last_seen, peer_count, last,
		output ready
	);
endinterface

`default_nettype wire

### design/hlt_ctrl.sv
`default_nettype none

module hlt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  hlt_pkg::hlt_sts_t sts,
	output logic              in_ready,
	output hlt_pkg::hlt_ctl_t ctl
);
	import hlt_pkg::*;

	hlt_state_t state_q;
	hlt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !sts.cmd_nop) begin
					ctl.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				ctl.finish = 1'b1;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/hlt_dp.sv
`default_nettype none

module hlt_dp #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hlt_pkg::hlt_ctl_t         ctl,
	output hlt_pkg::hlt_sts_t         sts,
	input  logic                      cfg_we,
	input  logic [hlt_pkg::TIME_W-1:0] cfg_wdata,
	input  logic [hlt_pkg::CODE_W-1:0] cmd,
	input  logic [hlt_pkg::KEY_W-1:0]  device_key,
	input  logic [hlt_pkg::TIME_W-1:0] now_ms,
	input  logic [hlt_pkg::ADDR_W-1:0] peer_addr,
	input  logic                      addr_present,
	input  logic [hlt_pkg::PORT_W-1:0] peer_port,
	hlt_out_if.source                 result
);
	import hlt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] ENTRIES  = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	hlt_rec_t mem_q [TABLE_ENTRIES];

	logic [CODE_W-1:0]        cmd_q;
	logic [KEY_W-1:0]         key_q;
	logic [TIME_W-1:0]        now_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     addr_pres_q;
	logic [PORT_W-1:0]        port_q;
	logic [TIME_W-1:0]        timeout_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] valid_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_d;

	logic [CNT_W-1:0] issue_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	hlt_rec_t         rdata_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	hlt_rec_t         rec_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic               out_vld_q;
	logic [CODE_W-1:0]  out_status_q;
	logic [CODE_W-1:0]  out_kind_q;
	logic [SLOT_W-1:0]  out_slot_q;
	hlt_rec_t           out_rec_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic              issue_ok;
	logic              row_valid;
	logic [TIME_W-1:0] silent;
	logic              expire;
	logic              out_free;
	logic              stall;
	logic              adv;
	logic              eval;
	logic              match;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	hlt_rec_t          upd;

	logic              o_load;
	logic [CODE_W-1:0] o_status;
	logic [CODE_W-1:0] o_kind;
	logic [SLOT_W-1:0] o_slot;
	hlt_rec_t          o_rec;
	logic              o_last;

	assign issue_ok  = issue_q < ENTRIES;
	assign row_valid = valid_q[idx_s1];
	assign silent    = now_q - rdata_s1.last_seen;
	assign expire    = ctl.scan && vld_s1 && (cmd_q == CMD_SWEEP) && row_valid &&
		(silent > timeout_q);
	assign out_free  = !out_vld_q || result.ready;
	assign stall     = expire && !out_free;
	assign adv       = ctl.scan && !stall;
	assign eval      = ctl.scan && vld_s1 && !stall;
	assign match     = row_valid && (rdata_s1.key == key_q);

	assign sts.cmd_nop  = (cmd == CMD_NONE);
	assign sts.scan_end = eval && (idx_s1 == LAST_IDX);
	assign sts.out_free = out_free;

	assign mem_we    = ctl.finish && out_free && (cmd_q == CMD_BEAT) && (hit_q || free_q);
	assign mem_waddr = hit_q ? hit_idx_q : free_idx_q;

	// A known peer keeps its record; a new one starts from a cleared record.
	always_comb begin
		if (hit_q) begin
			upd = rec_q;
		end else begin
			upd            = '0;
			upd.first_seen = now_q;
		end
		upd.key       = key_q;
		upd.port      = port_q;
		upd.last_seen = now_q;
		if (addr_pres_q) begin
			upd.addr = addr_q;
		end
	end

	always_comb begin
		valid_d  = valid_q;
		cnt_d    = cnt_q;
		o_load   = 1'b0;
		o_status = ST_OK;
		o_kind   = EV_NONE;
		o_slot   = '0;
		o_rec    = '0;
		o_last   = 1'b1;
		if (expire && out_free) begin
			valid_d[idx_s1] = 1'b0;
			cnt_d           = cnt_q - CNT_W'(1);
			o_load          = 1'b1;
			o_kind          = EV_OFFLINE;
			o_slot          = SLOT_W'(idx_s1);
			o_rec           = rdata_s1;
			o_last          = 1'b0;
		end
		if (ctl.finish && out_free) begin
			o_load = 1'b1;
			case (cmd_q)
				CMD_BEAT: begin
					if (hit_q || free_q) begin
						o_slot = SLOT_W'(mem_waddr);
						o_rec  = upd;
						if (!hit_q) begin
							valid_d[free_idx_q] = 1'b1;
							cnt_d               = cnt_q + CNT_W'(1);
							o_kind              = EV_ONLINE;
						end
					end else begin
						o_status  = ST_FULL;
						o_rec.key = key_q;
					end
				end
				CMD_LOOKUP: begin
					if (hit_q) begin
						o_slot = SLOT_W'(hit_idx_q);
						o_rec  = rec_q;
					end else begin
						o_status  = ST_NOT_FOUND;
						o_rec.key = key_q;
					end
				end
				CMD_SWEEP: begin
					o_kind = EV_NONE;
				end
				default: begin
					o_kind = EV_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			valid_q   <= '0;
			cnt_q     <= '0;
			issue_q   <= '0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			valid_q <= valid_d;
			cnt_q   <= cnt_d;
			if (ctl.load) begin
				issue_q <= '0;
				vld_s1  <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (adv) begin
					vld_s1 <= issue_ok;
					if (issue_ok) begin
						issue_q <= issue_q + CNT_W'(1);
					end
				end
				if (eval && (cmd_q != CMD_SWEEP)) begin
					if (match) begin
						hit_q <= 1'b1;
					end
					if (!row_valid) begin
						free_q <= 1'b1;
					end
				end
			end
			if (o_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q       <= cmd;
			key_q       <= device_key;
			now_q       <= now_ms;
			addr_q      <= peer_addr;
			addr_pres_q <= addr_present;
			port_q      <= peer_port;
		end
		if (adv && issue_ok) begin
			idx_s1   <= issue_q[IDX_W-1:0];
			rdata_s1 <= mem_q[issue_q[IDX_W-1:0]];
		end
		if (mem_we) begin
			mem_q[mem_waddr] <= upd;
		end
		if (eval && match && !hit_q) begin
			hit_idx_q <= idx_s1;
			rec_q     <= rdata_s1;
		end
		if (eval && !row_valid && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (o_load) begin
			out_status_q <= o_status;
			out_kind_q   <= o_kind;
			out_slot_q   <= o_slot;
			out_rec_q    <= o_rec;
			out_count_q  <= COUNT_W'(cnt_d);
			out_last_q   <= o_last;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.status      = out_status_q;
	assign result.event_kind  = out_kind_q;
	assign result.result_key  = out_rec_q.key;
	assign result.slot_index  = out_slot_q;
	assign result.stored_addr = out_rec_q.addr;
	assign result.stored_port = out_rec_q.port;
	assign result.first_seen  = out_rec_q.first_seen;
	assign result.last_seen   = out_rec_q.last_seen;
	assign result.peer_count  = out_count_q;
	assign result.last        = out_last_q;

endmodule

`default_nettype wire

### design/heartbeat_liveness_table.sv
// Channel   Direction  Handshake       Payload
// item      in         valid / ready   cmd, device_key, now_ms, peer_addr, addr_present, peer_port
// result    out        valid / ready   status, event_kind, result_key, slot_index, record, count, last
// cfg       in         cfg_we          cfg_wdata (offline timeout)
//
// Every beat, sweep or lookup walks the record memory one slot per cycle, except while a sweep
// stalls, through its single read port; the input is ready again once its closing result is loaded.
// An unused command code is taken and dropped without a scan.
// Reset clears the valid bits and the live count but not the record memory; there is no clearing pass.
// A sweep pauses on a slot while its offline result waits to be taken.
// The last result of an item stays in the output register while the next item is accepted.
`default_nettype none
`include "heartbeat_liveness_table_defines.svh"

module heartbeat_liveness_table #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hlt_pkg::TIME_W-1:0] cfg_wdata,
	hlt_in_if.sink                     item,
	hlt_out_if.source                  result
);
	import hlt_pkg::*;

	hlt_ctl_t ctl;
	hlt_sts_t sts;
	logic     in_ready;

	assign item.ready = in_ready;

	hlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	hlt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (item.cmd),
		.device_key   (item.device_key),
		.now_ms       (item.now_ms),
		.peer_addr    (item.peer_addr),
		.addr_present (item.addr_present),
		.peer_port    (item.peer_port),
		.result       (result)
	);

	`HLT_ASSERT_SAME(a_ready_only_idle, item.ready, !ctl.scan && !ctl.finish, "input ready while busy")
	`HLT_ASSERT_NEXT(a_scan_to_finish, sts.scan_end, ctl.finish, "scan end did not reach finish")
	`HLT_ASSERT_NEXT(a_finish_gives_last, ctl.finish && sts.out_free, result.valid && result.last, "closing result missing")
	`HLT_ASSERT_SAME(a_offline_not_last, result.valid && (result.event_kind == EV_OFFLINE), !result.last, "offline result marked last")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps

import hlt_pkg::*;

localparam int TABLE_SLOTS = 32;

typedef struct packed {
	logic [CODE_W-1:0] cmd;
	logic [KEY_W-1:0]  key;
	logic [TIME_W-1:0] now;
	logic [ADDR_W-1:0] addr;
	logic              addr_present;
	logic [PORT_W-1:0] port;
} peer_cmd_t;

typedef struct packed {
	logic [CODE_W-1:0]  status;
	logic [CODE_W-1:0]  event_kind;
	logic [KEY_W-1:0]   key;
	logic [SLOT_W-1:0]  slot;
	logic [ADDR_W-1:0]  addr;
	logic [PORT_W-1:0]  port;
	logic [TIME_W-1:0]  first_seen;
	logic [TIME_W-1:0]  last_seen;
	logic [COUNT_W-1:0] count;
	logic               closing;
} peer_report_t;

class peer_table_model;
	bit                slot_used[TABLE_SLOTS];
	logic [KEY_W-1:0]  slot_key[TABLE_SLOTS];
	logic [ADDR_W-1:0] slot_addr[TABLE_SLOTS];
	logic [PORT_W-1:0] slot_port[TABLE_SLOTS];
	logic [TIME_W-1:0] slot_first[TABLE_SLOTS];
	logic [TIME_W-1:0] slot_last[TABLE_SLOTS];
	int unsigned       live_peers;
	logic [TIME_W-1:0] timeout_ms;
	peer_report_t      expected_reports[$];
	int unsigned       failures;

	function new();
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		live_peers = 0;
		timeout_ms = TIMEOUT_RESET;
		failures   = 0;
	endfunction

	function void set_timeout(logic [TIME_W-1:0] value);
		timeout_ms = value;
	endfunction

	function int find_slot(logic [KEY_W-1:0] key);
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (slot_used[i] && slot_key[i] == key)
				return i;
		end
		return -1;
	endfunction

	function void push_report(logic [CODE_W-1:0] status, logic [CODE_W-1:0] kind,
		logic [KEY_W-1:0] key, int slot, bit closing);
		peer_report_t r;
		r            = '0;
		r.status     = status;
		r.event_kind = kind;
		r.key        = key;
		r.count      = COUNT_W'(live_peers);
		r.closing    = closing;
		if (slot >= 0) begin
			r.slot       = SLOT_W'(slot);
			r.addr       = slot_addr[slot];
			r.port       = slot_port[slot];
			r.first_seen = slot_first[slot];
			r.last_seen  = slot_last[slot];
		end
		expected_reports.push_back(r);
	endfunction

	function void note_command(peer_cmd_t c);
		int                slot;
		bit                fresh;
		logic [TIME_W-1:0] silence;
		case (c.cmd)
			CMD_BEAT: begin
				fresh = 1'b0;
				slot  = find_slot(c.key);
				if (slot < 0) begin
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						if (!slot_used[i]) begin
							slot = i;
							break;
						end
					end
					if (slot < 0) begin
						push_report(ST_FULL, EV_NONE, c.key, -1, 1'b1);
						return;
					end
					fresh            = 1'b1;
					slot_used[slot]  = 1'b1;
					slot_key[slot]   = c.key;
					slot_addr[slot]  = '0;
					slot_first[slot] = c.now;
					live_peers++;
				end
				if (c.addr_present)
					slot_addr[slot] = c.addr;
				slot_port[slot] = c.port;
				slot_last[slot] = c.now;
				push_report(ST_OK, fresh ? EV_ONLINE : EV_NONE, c.key, slot, 1'b1);
			end
			CMD_SWEEP: begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot_used[i]) begin
						silence = c.now - slot_last[i];
						if (silence > timeout_ms) begin
							slot_used[i] = 1'b0;
							if (live_peers > 0)
								live_peers--;
							push_report(ST_OK, EV_OFFLINE, slot_key[i], i, 1'b0);
						end
					end
				end
				push_report(ST_OK, EV_NONE, '0, -1, 1'b1);
			end
			CMD_LOOKUP: begin
				slot = find_slot(c.key);
				if (slot < 0)
					push_report(ST_NOT_FOUND, EV_NONE, c.key, -1, 1'b1);
				else
					push_report(ST_OK, EV_NONE, c.key, slot, 1'b1);
			end
			default: begin
			end
		endcase
	endfunction

	function void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t: mismatch in %s, expected %0h, actual %0h", $time, field, want, got);
		end
	endfunction

	function void check_result(peer_report_t got);
		peer_report_t want;
		if (expected_reports.size() == 0) begin
			failures++;
			$display("%0t: unexpected result, expected none, actual key %0h kind %0d",
				$time, got.key, got.event_kind);
			return;
		end
		want = expected_reports.pop_front();
		compare_field("status", 64'(want.status), 64'(got.status));
		compare_field("event_kind", 64'(want.event_kind), 64'(got.event_kind));
		compare_field("result_key", want.key, got.key);
		compare_field("slot_index", 64'(want.slot), 64'(got.slot));
		compare_field("stored_addr", 64'(want.addr), 64'(got.addr));
		compare_field("stored_port", 64'(want.port), 64'(got.port));
		compare_field("first_seen", 64'(want.first_seen), 64'(got.first_seen));
		compare_field("last_seen", 64'(want.last_seen), 64'(got.last_seen));
		compare_field("peer_count", 64'(want.count), 64'(got.count));
		compare_field("last", 64'(want.closing), 64'(got.closing));
	endfunction
endclass

module tb;
	localparam int KEY_POOL    = 40;
	localparam int SETTLE_CYCS = TABLE_SLOTS + 8;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TIME_W-1:0] cfg_wdata;

	hlt_in_if  item_bus ();
	hlt_out_if result_bus ();

	heartbeat_liveness_table #(
		.TABLE_ENTRIES(TABLE_SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_bus),
		.result   (result_bus)
	);

	peer_table_model   roster = new();
	peer_report_t      seen;
	logic [KEY_W-1:0]  key_pool[KEY_POOL];
	logic [TIME_W-1:0] clock_ms;
	bit                gaps_on;
	bit                stalls_on;
	int                stall_left;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#10000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_pause(bit enabled);
		int r;
		r = $urandom_range(0, 15);
		if (!enabled || r < 8)
			return 0;
		if (r < 15)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic peer_cmd_t make_cmd(logic [CODE_W-1:0] cmd, logic [KEY_W-1:0] key,
		logic [TIME_W-1:0] now, logic [ADDR_W-1:0] addr, logic present, logic [PORT_W-1:0] port);
		peer_cmd_t c;
		c.cmd          = cmd;
		c.key          = key;
		c.now          = now;
		c.addr         = addr;
		c.addr_present = present;
		c.port         = port;
		return c;
	endfunction

	function automatic peer_cmd_t random_cmd();
		peer_cmd_t c;
		int        pick;
		int        step;
		step = $urandom_range(0, 19);
		if (step < 14)
			clock_ms += $urandom_range(0, 1500);
		else if (step < 19)
			clock_ms += $urandom_range(1500, 8000);
		else
			clock_ms += $urandom;
		pick           = $urandom_range(0, 99);
		c.key          = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, KEY_POOL - 1)];
		c.now          = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
		c.addr         = $urandom;
		c.addr_present = 1'($urandom_range(0, 1));
		c.port         = PORT_W'($urandom_range(0, 65535));
		if (pick < 55)
			c.cmd = CMD_BEAT;
		else if (pick < 72)
			c.cmd = CMD_SWEEP;
		else if (pick < 95)
			c.cmd = CMD_LOOKUP;
		else
			c.cmd = CMD_NONE;
		return c;
	endfunction

	task automatic send_item(peer_cmd_t c);
		int gap;
		gap = pick_pause(gaps_on);
		@(negedge clk);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid        <= 1'b1;
		item_bus.cmd          <= c.cmd;
		item_bus.device_key   <= c.key;
		item_bus.now_ms       <= c.now;
		item_bus.peer_addr    <= c.addr;
		item_bus.addr_present <= c.addr_present;
		item_bus.peer_port    <= c.port;
		@(posedge clk);
		while (item_bus.ready !== 1'b1) @(posedge clk);
		roster.note_command(c);
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_bus.valid <= 1'b0;
		while (roster.expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_timeout(logic [TIME_W-1:0] value);
		drain_results();
		repeat (SETTLE_CYCS) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		roster.set_timeout(value);
	endtask

	task automatic run_random(int count);
		repeat (count) send_item(random_cmd());
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_bus.ready <= 1'b0;
			stall_left--;
		end else begin
			result_bus.ready <= 1'b1;
			stall_left = pick_pause(stalls_on);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			seen.status     = result_bus.status;
			seen.event_kind = result_bus.event_kind;
			seen.key        = result_bus.result_key;
			seen.slot       = result_bus.slot_index;
			seen.addr       = result_bus.stored_addr;
			seen.port       = result_bus.stored_port;
			seen.first_seen = result_bus.first_seen;
			seen.last_seen  = result_bus.last_seen;
			seen.count      = result_bus.peer_count;
			seen.closing    = result_bus.last;
			roster.check_result(seen);
		end
	end

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		item_bus.valid        = 1'b0;
		item_bus.cmd          = CMD_NONE;
		item_bus.device_key   = '0;
		item_bus.now_ms       = '0;
		item_bus.peer_addr    = '0;
		item_bus.addr_present = 1'b0;
		item_bus.peer_port    = '0;
		result_bus.ready      = 1'b0;
		stall_left            = 0;
		gaps_on               = 1'b1;
		stalls_on             = 1'b1;
		clock_ms              = '0;
		key_pool[0]           = '0;
		key_pool[1]           = '1;
		for (int k = 2; k < KEY_POOL; k++) key_pool[k] = {$urandom, $urandom};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Silence of exactly the timeout keeps a peer; one more millisecond across the
		// wrap of the time counter drops it.
		send_item(make_cmd(CMD_BEAT, '0, 32'hFFFF_FF00, '1, 1'b1, 16'hFFFF));
		send_item(make_cmd(CMD_BEAT, '1, 32'hFFFF_FFFF, '0, 1'b0, 16'h0000));
		send_item(make_cmd(CMD_BEAT, '0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 16'h1234));
		send_item(make_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0));
		send_item(make_cmd(CMD_LOOKUP, 64'd5, '0, '0, 1'b0, '0));
		send_item(make_cmd(CMD_LOOKUP, '1, '0, '0, 1'b0, '0));
		send_item(make_cmd(CMD_NONE, '1, '1, '1, 1'b1, '1));
		send_item(make_cmd(CMD_SWEEP, '0, 32'd4999, '0, 1'b0, '0));
		send_item(make_cmd(CMD_SWEEP, '0, 32'd5000, '0, 1'b0, '0));
		send_item(make_cmd(CMD_SWEEP, '0, 32'd5000, '0, 1'b0, '0));
		send_item(make_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0, '0));
		send_item(make_cmd(CMD_BEAT, 64'h8000_0000_0000_0000, '0, 32'h8000_0000, 1'b1,
			16'h8000));

		write_timeout('0);
		send_item(make_cmd(CMD_SWEEP, '0, 32'd0, '0, 1'b0, '0));
		send_item(make_cmd(CMD_SWEEP, '0, 32'd1, '0, 1'b0, '0));
		clock_ms = 32'd1;
		run_random(55);

		// Nothing can expire here, so a pass over the whole key pool fills the table.
		write_timeout('1);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		for (int k = 0; k < KEY_POOL; k++) begin
			clock_ms += $urandom_range(0, 50);
			send_item(make_cmd(CMD_BEAT, key_pool[k], clock_ms, $urandom,
				1'($urandom_range(0, 1)), PORT_W'($urandom_range(0, 65535))));
		end
		run_random(30);

		write_timeout($urandom_range(0, 20000));
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		clock_ms += 32'd1000000;
		send_item(make_cmd(CMD_SWEEP, '0, clock_ms, '0, 1'b0, '0));
		run_random(75);

		write_timeout(TIMEOUT_RESET);
		gaps_on = 1'b0;
		run_random(30);
		drain_results();
		gaps_on = 1'b1;
		run_random(30);

		drain_results();
		repeat (SETTLE_CYCS) @(posedge clk);
		if (roster.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### heartbeat_liveness_table.f
+incdir+design
design/hlt_pkg.sv
design/hlt_if.sv
design/hlt_ctrl.sv
design/hlt_dp.sv
design/heartbeat_liveness_table.sv
tb/tb.sv
